>>> hdl/fwcr_pkg.sv
// Shared types and constants for the field-weakening current regulator.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package fwcr_pkg;

	// Current limits, Q1.15 magnitudes; defaults of the top-level parameters.
	localparam logic [14:0] CUR_LIMIT  = 15'd16384;
	localparam logic [14:0] SLEW_LIMIT = 15'd1638;

	// Configuration register indexes.
	localparam logic [2:0] REG_ENTER_LEVEL      = 3'd0;
	localparam logic [2:0] REG_EXIT_LEVEL       = 3'd1;
	localparam logic [2:0] REG_START_SPEED      = 3'd2;
	localparam logic [2:0] REG_HOLD_MARGIN      = 3'd3;
	localparam logic [2:0] REG_OVERSPEED_MARGIN = 3'd4;
	localparam logic [2:0] REG_GAIN_FULL        = 3'd5;
	localparam logic [2:0] REG_GAIN_HOLD        = 3'd6;
	localparam logic [2:0] REG_RELEASE_STEP     = 3'd7;

	// Register values after reset.
	localparam logic [15:0] ENTER_LEVEL_RST      = 16'd15565;
	localparam logic [15:0] EXIT_LEVEL_RST       = 16'd14746;
	localparam logic [15:0] START_SPEED_RST      = 16'd100;
	localparam logic [15:0] HOLD_MARGIN_RST      = 16'd50;
	localparam logic [15:0] OVERSPEED_MARGIN_RST = 16'd100;
	localparam logic [15:0] GAIN_FULL_RST        = 16'd256;
	localparam logic [15:0] GAIN_HOLD_RST        = 16'd64;
	localparam logic [14:0] RELEASE_STEP_RST     = 15'd16;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the input transaction
		logic sq_d;      // square volt_d
		logic sq_q;      // square volt_q, keep volt_d squared
		logic sum;       // add the squares, set up the root, take speed magnitudes
		logic root_step; // one bit of the square root
		logic mul;       // gain times voltage excess
		logic upd;       // update the current and load the result register
	} fwcr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic root_last; // the current root step is the last one
	} fwcr_status_t;

endpackage

>>> hdl/fwcr_ctrl.sv
// Sequencing state machine of the field-weakening current regulator.
// Drives fwcr_pkg::fwcr_cmd_t commands and owns the output valid flag.
`timescale 1ns / 1ps

module fwcr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  fwcr_pkg::fwcr_status_t status,
	output fwcr_pkg::fwcr_cmd_t    cmd
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SQD  = 7'b0000010,
		ST_SQQ  = 7'b0000100,
		ST_SUM  = 7'b0001000,
		ST_ROOT = 7'b0010000,
		ST_MUL  = 7'b0100000,
		ST_UPD  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   upd_fire;

	// The result register may be loaded when it is empty or being drained.
	assign upd_fire = (state_q == ST_UPD) && (!out_valid_q || m_tready);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid) state_d = ST_SQD;
			ST_SQD:  state_d = ST_SQQ;
			ST_SQQ:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_ROOT;
			ST_ROOT: if (status.root_last) state_d = ST_MUL;
			ST_MUL:  state_d = ST_UPD;
			ST_UPD:  if (upd_fire) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && s_tvalid;
		cmd.sq_d      = (state_q == ST_SQD);
		cmd.sq_q      = (state_q == ST_SQQ);
		cmd.sum       = (state_q == ST_SUM);
		cmd.root_step = (state_q == ST_ROOT);
		cmd.mul       = (state_q == ST_MUL);
		cmd.upd       = upd_fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (upd_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == ST_SQD)
		else $error("accepted transaction did not start the sequence");

	a_upd_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD && out_valid_q && !m_tready |=> state_q == ST_UPD && out_valid_q)
		else $error("update left while the result register was full");

	a_valid_from_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_UPD))
		else $error("result valid rose without an update");

endmodule

>>> hdl/fwcr_dp.sv
// Datapath of the field-weakening current regulator: configuration registers,
// shared multiplier, bit-serial square root and the current update. Uses fwcr_pkg.
`timescale 1ns / 1ps

module fwcr_dp #(
	parameter logic [14:0] CUR_LIMIT  = fwcr_pkg::CUR_LIMIT,
	parameter logic [14:0] SLEW_LIMIT = fwcr_pkg::SLEW_LIMIT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fwcr_pkg::fwcr_cmd_t    cmd,
	output fwcr_pkg::fwcr_status_t status,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [15:0]           cfg_data,
	input  logic signed [15:0]    volt_d,
	input  logic signed [15:0]    volt_q,
	input  logic signed [16:0]    speed_meas,
	input  logic signed [16:0]    speed_goal,
	output logic signed [15:0]    id_target,
	output logic [15:0]           volt_magnitude,
	output logic                  weakening_on
);

	logic [15:0] enter_level_q;
	logic [15:0] exit_level_q;
	logic [15:0] start_speed_q;
	logic [15:0] hold_margin_q;
	logic [15:0] overspeed_margin_q;
	logic [15:0] gain_full_q;
	logic [15:0] gain_hold_q;
	logic [14:0] release_step_q;

	logic signed [15:0] weak_q;
	logic [3:0]         root_cnt_q;

	logic signed [15:0] vd_q;
	logic signed [15:0] vq_q;
	logic signed [16:0] sm_q;
	logic signed [16:0] sg_q;
	logic [16:0]        sabs_q;
	logic [16:0]        tabs_q;
	logic [31:0]        prod_q;
	logic [31:0]        sumsq_q;
	logic [31:0]        rad_q;
	logic [16:0]        rem_q;
	logic [15:0]        root_q;
	logic signed [15:0] id_target_q;
	logic [15:0]        mag_out_q;
	logic               on_q;

	logic signed [16:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [33:0] mul_p;
	logic [15:0]        gain_sel;
	logic [15:0]        excess;
	logic [18:0]        rem_next;
	logic [18:0]        trial;
	logic [18:0]        rem_diff;
	logic [17:0]        hold_sum;
	logic [17:0]        over_sum;
	logic               low_speed;
	logic               deepen;
	logic               release_cond;
	logic [24:0]        step_full;
	logic [14:0]        step_lim;
	logic signed [16:0] w_cur;
	logic signed [16:0] w_step;
	logic signed [16:0] w_new;
	logic signed [16:0] w_floor;

	assign w_floor = -$signed({2'b00, CUR_LIMIT});

	// Speed comparisons are done one bit wider so that margins never wrap.
	assign hold_sum     = {1'b0, sabs_q} + {2'b00, hold_margin_q};
	assign over_sum     = {1'b0, tabs_q} + {2'b00, overspeed_margin_q};
	assign low_speed    = tabs_q < {1'b0, start_speed_q};
	assign deepen       = (root_q > enter_level_q) && (sabs_q < tabs_q);
	assign release_cond = (root_q < exit_level_q) || ({1'b0, sabs_q} > over_sum);
	assign gain_sel     = (hold_sum < {1'b0, tabs_q}) ? gain_full_q : gain_hold_q;
	assign excess       = root_q - enter_level_q;

	// One multiplier serves both squares and the gain product.
	always_comb begin
		if (cmd.sq_d) begin
			mul_a = {vd_q[15], vd_q};
			mul_b = {vd_q[15], vd_q};
		end else if (cmd.sq_q) begin
			mul_a = {vq_q[15], vq_q};
			mul_b = {vq_q[15], vq_q};
		end else begin
			mul_a = $signed({1'b0, gain_sel});
			mul_b = $signed({1'b0, excess});
		end
	end
	assign mul_p = mul_a * mul_b;

	// Square root: two radicand bits enter the partial remainder per step.
	assign rem_next = {rem_q, rad_q[31:30]};
	assign trial    = {1'b0, root_q, 2'b01};
	assign rem_diff = rem_next - trial;

	assign status.root_last = &root_cnt_q;

	assign step_full = prod_q[31:7];
	assign step_lim  = (step_full > {10'd0, SLEW_LIMIT}) ?
		SLEW_LIMIT : step_full[14:0];
	assign w_cur     = {weak_q[15], weak_q};

	always_comb begin
		w_step = w_cur;
		if (low_speed) begin
			w_step = '0;
		end else if (deepen) begin
			w_step = w_cur - $signed({2'b00, step_lim});
		end else if (release_cond && w_cur[16]) begin
			w_step = w_cur + $signed({2'b00, release_step_q});
		end
		w_new = w_step;
		if (w_step < w_floor) begin
			w_new = w_floor;
		end else if (!w_step[16] && (w_step != '0)) begin
			w_new = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_level_q      <= fwcr_pkg::ENTER_LEVEL_RST;
			exit_level_q       <= fwcr_pkg::EXIT_LEVEL_RST;
			start_speed_q      <= fwcr_pkg::START_SPEED_RST;
			hold_margin_q      <= fwcr_pkg::HOLD_MARGIN_RST;
			overspeed_margin_q <= fwcr_pkg::OVERSPEED_MARGIN_RST;
			gain_full_q        <= fwcr_pkg::GAIN_FULL_RST;
			gain_hold_q        <= fwcr_pkg::GAIN_HOLD_RST;
			release_step_q     <= fwcr_pkg::RELEASE_STEP_RST;
			weak_q             <= '0;
			root_cnt_q         <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					fwcr_pkg::REG_ENTER_LEVEL:      enter_level_q      <= cfg_data;
					fwcr_pkg::REG_EXIT_LEVEL:       exit_level_q       <= cfg_data;
					fwcr_pkg::REG_START_SPEED:      start_speed_q      <= cfg_data;
					fwcr_pkg::REG_HOLD_MARGIN:      hold_margin_q      <= cfg_data;
					fwcr_pkg::REG_OVERSPEED_MARGIN: overspeed_margin_q <= cfg_data;
					fwcr_pkg::REG_GAIN_FULL:        gain_full_q        <= cfg_data;
					fwcr_pkg::REG_GAIN_HOLD:        gain_hold_q        <= cfg_data;
					fwcr_pkg::REG_RELEASE_STEP:     release_step_q     <= cfg_data[14:0];
					default: ;
				endcase
			end
			if (cmd.sum) begin
				root_cnt_q <= '0;
			end else if (cmd.root_step) begin
				root_cnt_q <= root_cnt_q + 4'd1;
			end
			if (cmd.upd) begin
				weak_q <= w_new[15:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			vd_q <= volt_d;
			vq_q <= volt_q;
			sm_q <= speed_meas;
			sg_q <= speed_goal;
		end
		if (cmd.sq_d || cmd.sq_q || cmd.mul) begin
			prod_q <= mul_p[31:0];
		end
		if (cmd.sq_q) begin
			sumsq_q <= prod_q;
		end
		if (cmd.sum) begin
			rad_q  <= sumsq_q + prod_q;
			rem_q  <= '0;
			root_q <= '0;
			sabs_q <= sm_q[16] ? 17'(-sm_q) : 17'(sm_q);
			tabs_q <= sg_q[16] ? 17'(-sg_q) : 17'(sg_q);
		end else if (cmd.root_step) begin
			rad_q <= {rad_q[29:0], 2'b00};
			if (rem_next >= trial) begin
				rem_q  <= rem_diff[16:0];
				root_q <= {root_q[14:0], 1'b1};
			end else begin
				rem_q  <= rem_next[16:0];
				root_q <= {root_q[14:0], 1'b0};
			end
		end
		if (cmd.upd) begin
			id_target_q <= w_new[15:0];
			mag_out_q   <= root_q;
			on_q        <= w_new[16];
		end
	end

	assign id_target      = id_target_q;
	assign volt_magnitude = mag_out_q;
	assign weakening_on   = on_q;

	a_current_range: assert property (@(posedge clk) disable iff (!arst_n)
		!weak_q[15] |-> weak_q == '0)
		else $error("field-weakening current went positive");

	a_current_floor: assert property (@(posedge clk) disable iff (!arst_n)
		$signed({weak_q[15], weak_q}) >= w_floor)
		else $error("field-weakening current below its limit");

endmodule

>>> hdl/field_weakening_current_regulator_core.sv
// Top level of the field-weakening current regulator.
// Instantiates fwcr_ctrl and fwcr_dp; uses fwcr_pkg.
`timescale 1ns / 1ps

// One input transaction per control tick carries the dq voltage command and the
// measured and target speeds; one output transaction returns the new d-axis
// field-weakening current (Q1.15, between minus CUR_LIMIT, 16384 by default, and 0),
// the voltage magnitude (truncated square root, unsigned Q1.15) and a flag that
// is set while weakening is active.
// The block works on one item at a time: it takes the next input in the cycle
// after the result of the last one is loaded. The square root resolves one
// result bit per cycle. The result sits in an output register, so a new input
// is accepted while the previous result waits. Configuration is written
// through cfg_we, cfg_index and cfg_data, one register per cycle; the user must
// write it only while idle, which the block itself does not enforce.
module field_weakening_current_regulator_core #(
	parameter logic [14:0] CUR_LIMIT  = fwcr_pkg::CUR_LIMIT,
	parameter logic [14:0] SLEW_LIMIT = fwcr_pkg::SLEW_LIMIT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] volt_d, [31:16] volt_q, [48:32] speed_meas, [65:49] speed_goal
	input  logic [71:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [15:0] id_target, [31:16] volt_magnitude, [32] weakening_on
	output logic [39:0] m_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	fwcr_pkg::fwcr_cmd_t    cmd;
	fwcr_pkg::fwcr_status_t status;
	logic signed [15:0]     id_target;
	logic [15:0]            volt_magnitude;
	logic                   weakening_on;

	fwcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	fwcr_dp #(
		.CUR_LIMIT  (CUR_LIMIT),
		.SLEW_LIMIT (SLEW_LIMIT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.volt_d         ($signed(s_tdata[15:0])),
		.volt_q         ($signed(s_tdata[31:16])),
		.speed_meas     ($signed(s_tdata[48:32])),
		.speed_goal     ($signed(s_tdata[65:49])),
		.id_target      (id_target),
		.volt_magnitude (volt_magnitude),
		.weakening_on   (weakening_on)
	);

	assign m_tdata = {7'd0, weakening_on, volt_magnitude, id_target};

endmodule

>>> test/field_weakening_current_regulator_core_tb.sv
// Self-checking testbench for field_weakening_current_regulator_core.
// Holds its own predictor of the regulator in a small scoreboard class; needs the
// RTL and fwcr_pkg only.
`timescale 1ns / 1ps

module field_weakening_current_regulator_core_tb;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 30;

	typedef struct {
		logic [15:0] id_target;
		logic [15:0] volt_magnitude;
		logic        weakening_on;
	} fw_result_t;

	class fw_scoreboard;
		logic [15:0] enter_lvl, exit_lvl, start_spd, hold_mgn, over_mgn, k_full, k_hold;
		logic [14:0] rel_step;
		longint      id_now;
		fw_result_t  expected_q[$];
		int          errors;

		function new();
			enter_lvl  = fwcr_pkg::ENTER_LEVEL_RST;
			exit_lvl   = fwcr_pkg::EXIT_LEVEL_RST;
			start_spd  = fwcr_pkg::START_SPEED_RST;
			hold_mgn   = fwcr_pkg::HOLD_MARGIN_RST;
			over_mgn   = fwcr_pkg::OVERSPEED_MARGIN_RST;
			k_full     = fwcr_pkg::GAIN_FULL_RST;
			k_hold     = fwcr_pkg::GAIN_HOLD_RST;
			rel_step   = fwcr_pkg::RELEASE_STEP_RST;
			id_now     = 0;
			errors     = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] val);
			case (idx)
				fwcr_pkg::REG_ENTER_LEVEL:      enter_lvl = val;
				fwcr_pkg::REG_EXIT_LEVEL:       exit_lvl  = val;
				fwcr_pkg::REG_START_SPEED:      start_spd = val;
				fwcr_pkg::REG_HOLD_MARGIN:      hold_mgn  = val;
				fwcr_pkg::REG_OVERSPEED_MARGIN: over_mgn  = val;
				fwcr_pkg::REG_GAIN_FULL:        k_full    = val;
				fwcr_pkg::REG_GAIN_HOLD:        k_hold    = val;
				fwcr_pkg::REG_RELEASE_STEP:     rel_step  = val[14:0];
				default: ;
			endcase
		endfunction

		// Bitwise integer square root, truncating.
		function logic [15:0] root_of(logic [31:0] n);
			logic [31:0] r;
			logic [31:0] b;
			r = 0;
			b = 32'h4000_0000;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r[15:0];
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_input(logic [71:0] d);
			longint     vd, vq, sm, sg, sabs, tabs, gain, stp, w;
			logic [31:0] sumsq;
			logic [15:0] mag;
			fw_result_t exp_res;
			vd = $signed(d[15:0]);
			vq = $signed(d[31:16]);
			sm = $signed(d[48:32]);
			sg = $signed(d[65:49]);
			sumsq = 32'(vd * vd + vq * vq);
			mag = root_of(sumsq);
			sabs = (sm < 0) ? -sm : sm;
			tabs = (sg < 0) ? -sg : sg;
			w = id_now;
			if (tabs < longint'(start_spd)) begin
				w = 0;
			end else if (mag > enter_lvl && sabs < tabs) begin
				gain = (sabs < tabs - longint'(hold_mgn)) ? longint'(k_full) : longint'(k_hold);
				stp = (gain * (longint'(mag) - longint'(enter_lvl))) >>> 7;
				if (stp > longint'(fwcr_pkg::SLEW_LIMIT)) stp = longint'(fwcr_pkg::SLEW_LIMIT);
				w = w - stp;
			end else if (mag < exit_lvl || sabs > tabs + longint'(over_mgn)) begin
				if (w < 0) begin
					w = w + longint'(rel_step);
					if (w > 0) w = 0;
				end
			end
			if (w < -longint'(fwcr_pkg::CUR_LIMIT)) w = -longint'(fwcr_pkg::CUR_LIMIT);
			if (w > 0) w = 0;
			id_now = w;
			exp_res.id_target      = 16'(w);
			exp_res.volt_magnitude = mag;
			exp_res.weakening_on   = (w < 0);
			expected_q.push_back(exp_res);
		endfunction

		function void check_result(logic [39:0] d);
			fw_result_t exp_res;
			if (expected_q.size() == 0) begin
				$error("result transaction with no expectation waiting: %h", d);
				errors++;
				return;
			end
			exp_res = expected_q.pop_front();
			if (d[15:0] !== exp_res.id_target) begin
				$error("id_target: expected %0d, got %0d",
					$signed(exp_res.id_target), $signed(d[15:0]));
				errors++;
			end
			if (d[31:16] !== exp_res.volt_magnitude) begin
				$error("volt_magnitude: expected %0d, got %0d",
					exp_res.volt_magnitude, d[31:16]);
				errors++;
			end
			if (d[32] !== exp_res.weakening_on) begin
				$error("weakening_on: expected %0b, got %0b", exp_res.weakening_on, d[32]);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	fw_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles = 0;

	field_weakening_current_regulator_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic logic [71:0] pack_item(int vd, int vq, int sm, int sg);
		logic [15:0] d16;
		logic [15:0] q16;
		logic [16:0] m17;
		logic [16:0] g17;
		d16 = vd[15:0];
		q16 = vq[15:0];
		m17 = sm[16:0];
		g17 = sg[16:0];
		return {6'b0, g17, m17, q16, d16};
	endfunction

	// Most items are shaped around the current settings so that the current really
	// integrates and releases; the rest are fully random.
	function automatic logic [71:0] random_item();
		logic [15:0] r16;
		logic [16:0] r17;
		int vd, vq, sm, sg, goal_abs, meas_abs, kind;
		kind = $urandom_range(0, 9);
		r16 = 16'($urandom);
		vd = $signed(r16);
		r16 = 16'($urandom);
		vq = $signed(r16);
		if ($urandom_range(0, 2) == 0) begin
			vd = vd >>> $urandom_range(1, 3);
			vq = vq >>> $urandom_range(1, 3);
		end
		goal_abs = int'(sb.start_spd) + $urandom_range(0, 3000);
		if (goal_abs > 65535) goal_abs = 65535;
		if (kind <= 5) begin
			meas_abs = goal_abs - $urandom_range(0, 2 * int'(sb.hold_mgn) + 20);
			if (meas_abs < 0) meas_abs = 0;
		end else begin
			meas_abs = goal_abs + int'(sb.over_mgn) + $urandom_range(1, 200);
			if (meas_abs > 65535) meas_abs = 65535;
		end
		sg = $urandom_range(0, 1) ? -goal_abs : goal_abs;
		sm = $urandom_range(0, 1) ? -meas_abs : meas_abs;
		if (kind >= 8) begin
			r17 = 17'($urandom);
			sm = $signed(r17);
			r17 = 17'($urandom);
			sg = $signed(r17);
		end
		return pack_item(vd, vq, sm, sg);
	endfunction

	task automatic send_item(logic [71:0] d);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		sb.note_input(d);
	endtask

	// Stops the input stream and waits for every outstanding result.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic apply_setting(int which);
		logic [15:0] enter_v;
		logic [15:0] exit_v;
		enter_v = 16'($urandom_range(8000, 40000));
		exit_v  = 16'(enter_v - $urandom_range(0, 3000));
		case (which)
			1: begin
				write_reg(fwcr_pkg::REG_ENTER_LEVEL, 16'd0);
				write_reg(fwcr_pkg::REG_EXIT_LEVEL, 16'd0);
				write_reg(fwcr_pkg::REG_START_SPEED, 16'd0);
				write_reg(fwcr_pkg::REG_HOLD_MARGIN, 16'd0);
				write_reg(fwcr_pkg::REG_OVERSPEED_MARGIN, 16'd0);
				write_reg(fwcr_pkg::REG_GAIN_FULL, 16'hFFFF);
				write_reg(fwcr_pkg::REG_GAIN_HOLD, 16'hFFFF);
				write_reg(fwcr_pkg::REG_RELEASE_STEP, 16'h7FFF);
			end
			2: begin
				write_reg(fwcr_pkg::REG_ENTER_LEVEL, 16'd46341);
				write_reg(fwcr_pkg::REG_EXIT_LEVEL, 16'd46341);
				write_reg(fwcr_pkg::REG_START_SPEED, 16'hFFFF);
				write_reg(fwcr_pkg::REG_HOLD_MARGIN, 16'hFFFF);
				write_reg(fwcr_pkg::REG_OVERSPEED_MARGIN, 16'hFFFF);
				write_reg(fwcr_pkg::REG_GAIN_FULL, 16'd0);
				write_reg(fwcr_pkg::REG_GAIN_HOLD, 16'd0);
				write_reg(fwcr_pkg::REG_RELEASE_STEP, 16'd0);
			end
			default: begin
				write_reg(fwcr_pkg::REG_ENTER_LEVEL, enter_v);
				write_reg(fwcr_pkg::REG_EXIT_LEVEL, exit_v);
				write_reg(fwcr_pkg::REG_START_SPEED, 16'($urandom_range(0, 3000)));
				write_reg(fwcr_pkg::REG_HOLD_MARGIN, 16'($urandom_range(0, 3000)));
				write_reg(fwcr_pkg::REG_OVERSPEED_MARGIN, 16'($urandom_range(0, 3000)));
				write_reg(fwcr_pkg::REG_GAIN_FULL, 16'($urandom));
				write_reg(fwcr_pkg::REG_GAIN_HOLD, 16'($urandom));
				// Bit 15 of the data is written too; the register keeps 15 bits.
				write_reg(fwcr_pkg::REG_RELEASE_STEP, 16'($urandom));
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("field_weakening_current_regulator_core_tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		int phase;
		sb            = new();
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		send_idle_pct = 33;
		recv_idle_pct = 49;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed items at the reset settings. Full-scale voltage with a large speed
		// shortfall deepens at the slew limit until the current clamps at its limit.
		send_item(pack_item(0, 0, 0, 0));
		send_item(pack_item(32767, 32767, 0, 2000));
		send_item(pack_item(-32768, -32768, 100, -2000));
		send_item(pack_item(32767, -32768, -500, 3000));
		send_item(pack_item(-32768, 32767, 0, 65535));
		send_item(pack_item(-32768, 0, 10, 4000));
		send_item(pack_item(0, 32767, -10, 4000));
		send_item(pack_item(0, -32768, 0, -65536));
		send_item(pack_item(32767, 0, 65535, -65536));
		send_item(pack_item(-32768, -32768, 0, 2000));
		send_item(pack_item(-32768, -32768, 0, 2000));
		send_item(pack_item(-32768, -32768, 0, 2000));
		// Near the target speed the hold gain applies.
		send_item(pack_item(15600, 0, 1980, 2000));
		// Overspeed with high voltage releases.
		send_item(pack_item(32767, 32767, -2200, 2000));
		// Low voltage releases.
		send_item(pack_item(0, 0, 1000, 2000));
		// Voltage between the exit and enter levels holds the current.
		send_item(pack_item(15000, 0, 1000, 2000));
		// Equal speed magnitudes do not deepen.
		send_item(pack_item(32767, 32767, -2000, 2000));
		// A target exactly at the start speed is not zeroed.
		send_item(pack_item(32767, 32767, 0, 100));
		// A target below the start speed zeroes the current.
		send_item(pack_item(32767, 32767, 0, -99));
		send_item(pack_item(-32768, 32767, -65536, 65535));
		send_item(pack_item(1, -1, 0, 0));
		drain();

		for (phase = 0; phase < 6; phase++) begin
			if (phase == 2) begin
				send_idle_pct = 49;
				recv_idle_pct = 33;
			end else if (phase == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			apply_setting((phase == 1) ? 1 : (phase == 3) ? 2 : 0);
			repeat ((phase == 3) ? 60 : 100) begin
				if ($urandom_range(0, 39) == 0) drain();
				send_item(random_item());
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("field_weakening_current_regulator_core_tb: done, clean");
		end else begin
			$display("field_weakening_current_regulator_core_tb: done, errors");
		end
		$finish;
	end

endmodule
